// File: rtl/core/bmp24_to_rgb565_decoder_core_defines.svh
// Assertion macros for the decoder RTL.
`ifndef BMP24_TO_RGB565_DECODER_CORE_DEFINES_SVH
`define BMP24_TO_RGB565_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define BMP565_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bmp565 assertion failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define BMP565_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bmp565 assertion failed");

`endif

// File: rtl/core/bmp565_pkg.sv
// Types, constants and codes shared by the BMP to RGB565 decoder modules.
package bmp565_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   // row/column counters and latched image size
   localparam int DIM_W      = $clog2(MAX_DIM + 1);

   localparam int BYTE_W     = 8;
   localparam int FIELD_W    = 32;
   localparam int RGB_W      = 16;
   localparam int ADDR_W     = 22;
   localparam int OUT_DIM_W  = 12;

   localparam logic [FIELD_W-1:0] MAX_WIDTH_U  = FIELD_W'(MAX_WIDTH);
   localparam logic [FIELD_W-1:0] MAX_HEIGHT_U = FIELD_W'(MAX_HEIGHT);
   localparam logic [FIELD_W-1:0] HEADER_BYTES = 32'd54;
   localparam logic [15:0]        BMP_MAGIC    = 16'h4D42;
   localparam logic [15:0]        BMP_DEPTH    = 16'd24;

   // header byte positions
   localparam logic [FIELD_W-1:0] POS_MAGIC    = 32'd0;
   localparam logic [FIELD_W-1:0] POS_OFFSET   = 32'd10;
   localparam logic [FIELD_W-1:0] POS_WIDTH    = 32'd18;
   localparam logic [FIELD_W-1:0] POS_HEIGHT   = 32'd22;
   localparam logic [FIELD_W-1:0] POS_DEPTH    = 32'd28;
   localparam logic [FIELD_W-1:0] POS_COMP     = 32'd30;
   localparam logic [FIELD_W-1:0] POS_LAST_HDR = 32'd53;

   // byte within a BGR triple
   localparam logic [1:0] BIP_BLUE  = 2'd0;
   localparam logic [1:0] BIP_GREEN = 2'd1;
   localparam logic [1:0] BIP_RED   = 2'd2;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SKIP,
      PH_PIXELS,
      PH_PAD,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PIXEL      = 2'd0,
      KIND_BAD_FORMAT = 2'd1,
      KIND_TRUNCATED  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              start_of_file;
      logic              end_of_file;
   } req_word_type;

   typedef struct packed {
      kind_type             kind;
      logic [RGB_W-1:0]     pixel_rgb565;
      logic [ADDR_W-1:0]    pixel_address;
      logic [OUT_DIM_W-1:0] image_width;
      logic [OUT_DIM_W-1:0] image_height;
      logic                 last_pixel;
   } rsp_word_type;

   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } parse_result_type;

endpackage

// File: rtl/core/bmp24_to_rgb565_decoder_core.sv
// Top level of the byte-stream BMP (24-bit) to RGB565 decoder.
// Feeds a BMP file one byte per word and returns, per byte, at most one
// result: an RGB565 pixel with its top-row-first frame-buffer address, a
// bad-format report, or a truncated-file report. One byte is taken every
// cycle unless the output stalls; the path is an input register, one pass
// of header, counter and address logic (a single row-times-width multiply),
// and the result register, so each result is registered twice before it is visible.
// req_ready drops only while the result register is full and not taken.
// Start of file on any byte restarts the parser at that byte; after the
// last pixel or an error, bytes are dropped until the next start of file.
`include "bmp24_to_rgb565_decoder_core_defines.svh"

module bmp24_to_rgb565_decoder_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bmp565_pkg::req_word_type req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output bmp565_pkg::rsp_word_type rsp_word
);
   import bmp565_pkg::*;

   logic             in_valid_ff, in_valid_in;
   req_word_type     in_word_ff;
   logic             s1_fire;
   logic             out_space;
   parse_result_type res;

   assign s1_fire     = in_valid_ff && (!res.valid || out_space);
   assign req_ready   = !in_valid_ff || s1_fire;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !s1_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_word;
      end
   end

   bmp565_parser u_parser (
      .clock (clock),
      .reset (reset),
      .step  (s1_fire),
      .word  (in_word_ff),
      .res   (res)
   );

   bmp565_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (s1_fire && res.valid),
      .load_word (res.word),
      .space     (out_space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   `BMP565_ASSERT_NEXT(a_result_lands, s1_fire && res.valid, rsp_valid)
   `BMP565_ASSERT_IMPLIES(a_stall_only_full, !req_ready, in_valid_ff && rsp_valid && !rsp_ready)
   `BMP565_ASSERT_IMPLIES(a_last_is_pixel, rsp_valid && rsp_word.last_pixel, rsp_word.kind == KIND_PIXEL)

endmodule

// File: rtl/core/bmp565_parser.sv
// Header capture, format check and pixel walker; one byte per step.
module bmp565_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  bmp565_pkg::req_word_type     word,
   output bmp565_pkg::parse_result_type res
);
   import bmp565_pkg::*;

   phase_type          phase_ff, phase_in, phase_cur, phase_main;
   logic [FIELD_W-1:0] pos_ff, pos_in, pos_cur, pos_inc;
   logic [15:0]        magic_ff, magic_in;
   logic [FIELD_W-1:0] offset_ff, offset_in;
   logic [FIELD_W-1:0] width_ff, width_in;
   logic [FIELD_W-1:0] height_ff, height_in;
   logic [15:0]        depth_ff, depth_in;
   logic [FIELD_W-1:0] comp_ff, comp_in;
   logic [DIM_W-1:0]   row_ff, row_in, row_cur;
   logic [DIM_W-1:0]   col_ff, col_in, col_cur;
   logic [1:0]         bip_ff, bip_in, bip_cur;
   logic [1:0]         pad_ff, pad_in, pad_cur;
   logic [BYTE_W-1:0]  blue_ff, blue_in;
   logic [BYTE_W-1:0]  green_ff, green_in;
   logic [DIM_W-1:0]   img_w_ff, img_w_in;
   logic [DIM_W-1:0]   img_h_ff, img_h_in;
   logic               top_down_ff, top_down_in;

   logic               sof;
   logic [FIELD_W-1:0] habs;
   logic               hdr_ok;
   logic               hdr_end;
   logic               pix_done;
   logic [DIM_W:0]     row_inc, col_inc;
   logic               last_row, last_col;
   logic [1:0]         row_pad;
   logic [DIM_W-1:0]   dst_row;
   logic [2*DIM_W-1:0] row_base;
   logic [2*DIM_W:0]   addr_full;

   // start of file restarts the parser on this very byte
   assign sof       = word.start_of_file;
   assign phase_cur = sof ? PH_HEADER : phase_ff;
   assign pos_cur   = sof ? '0 : pos_ff;
   assign row_cur   = sof ? '0 : row_ff;
   assign col_cur   = sof ? '0 : col_ff;
   assign bip_cur   = sof ? BIP_BLUE : bip_ff;
   assign pad_cur   = sof ? '0 : pad_ff;
   assign pos_inc   = pos_cur + 32'd1;

   assign habs   = height_ff[FIELD_W-1] ? (~height_ff + 32'd1) : height_ff;
   assign hdr_ok = (magic_ff == BMP_MAGIC) && (depth_ff == BMP_DEPTH) &&
                   (comp_ff == '0) && (width_ff != '0) && !width_ff[FIELD_W-1] &&
                   (height_ff != '0) && (width_ff <= MAX_WIDTH_U) &&
                   (habs <= MAX_HEIGHT_U) && (offset_ff >= HEADER_BYTES);
   assign hdr_end = (pos_cur == POS_LAST_HDR);

   assign row_inc  = {1'b0, row_cur} + {{DIM_W{1'b0}}, 1'b1};
   assign col_inc  = {1'b0, col_cur} + {{DIM_W{1'b0}}, 1'b1};
   assign last_row = (row_inc >= {1'b0, img_h_ff});
   assign last_col = (col_inc >= {1'b0, img_w_ff});
   assign pix_done = (bip_cur != BIP_BLUE) && (bip_cur != BIP_GREEN);
   // 3*width mod 4 padding equals width mod 4
   assign row_pad  = 2'(img_w_ff);

   assign dst_row   = top_down_ff ? row_cur : (img_h_ff - DIM_W'(1) - row_cur);
   assign row_base  = {{DIM_W{1'b0}}, dst_row} * {{DIM_W{1'b0}}, img_w_ff};
   assign addr_full = {1'b0, row_base} + (2*DIM_W+1)'(col_cur);

   // next phase
   always_comb begin
      phase_main = phase_cur;
      unique case (phase_cur)
         PH_HEADER: begin
            if (hdr_end) begin
               if (!hdr_ok) begin
                  phase_main = PH_DONE;
               end else if (pos_inc >= offset_ff) begin
                  phase_main = PH_PIXELS;
               end else begin
                  phase_main = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            if (pos_inc >= offset_ff) phase_main = PH_PIXELS;
         end
         PH_PIXELS: begin
            if (pix_done) begin
               if (last_row && last_col) begin
                  phase_main = PH_DONE;
               end else if (last_col && (row_pad != 2'd0)) begin
                  phase_main = PH_PAD;
               end
            end
         end
         PH_PAD: begin
            if (pad_cur == 2'd1) phase_main = PH_PIXELS;
         end
         PH_DONE: phase_main = PH_DONE;
         default: phase_main = PH_DONE;
      endcase
      phase_in = (word.end_of_file && (phase_main != PH_DONE)) ? PH_DONE : phase_main;
   end

   // datapath and result
   always_comb begin
      pos_in      = pos_cur;
      magic_in    = sof ? '0 : magic_ff;
      offset_in   = sof ? '0 : offset_ff;
      width_in    = sof ? '0 : width_ff;
      height_in   = sof ? '0 : height_ff;
      depth_in    = sof ? '0 : depth_ff;
      comp_in     = sof ? '0 : comp_ff;
      row_in      = row_cur;
      col_in      = col_cur;
      bip_in      = bip_cur;
      pad_in      = pad_cur;
      blue_in     = blue_ff;
      green_in    = green_ff;
      img_w_in    = img_w_ff;
      img_h_in    = img_h_ff;
      top_down_in = top_down_ff;
      res         = '0;

      unique case (phase_cur)
         PH_HEADER: begin
            pos_in = pos_inc;
            for (int k = 0; k < 2; k++) begin
               if (pos_cur == POS_MAGIC + FIELD_W'(k)) magic_in[8*k +: 8] = word.data_byte;
               if (pos_cur == POS_DEPTH + FIELD_W'(k)) depth_in[8*k +: 8] = word.data_byte;
            end
            for (int k = 0; k < 4; k++) begin
               if (pos_cur == POS_OFFSET + FIELD_W'(k)) offset_in[8*k +: 8] = word.data_byte;
               if (pos_cur == POS_WIDTH + FIELD_W'(k)) width_in[8*k +: 8] = word.data_byte;
               if (pos_cur == POS_HEIGHT + FIELD_W'(k)) height_in[8*k +: 8] = word.data_byte;
               if (pos_cur == POS_COMP + FIELD_W'(k)) comp_in[8*k +: 8] = word.data_byte;
            end
            if (hdr_end) begin
               img_w_in    = DIM_W'(width_ff);
               img_h_in    = DIM_W'(habs);
               top_down_in = height_ff[FIELD_W-1];
               if (!hdr_ok) begin
                  res.valid     = 1'b1;
                  res.word.kind = KIND_BAD_FORMAT;
               end
            end
         end
         PH_SKIP: pos_in = pos_inc;
         PH_PIXELS: begin
            unique case (bip_cur)
               BIP_BLUE: begin
                  blue_in = word.data_byte;
                  bip_in  = BIP_GREEN;
               end
               BIP_GREEN: begin
                  green_in = word.data_byte;
                  bip_in   = BIP_RED;
               end
               default: begin
                  bip_in                  = BIP_BLUE;
                  res.valid               = 1'b1;
                  res.word.kind           = KIND_PIXEL;
                  res.word.pixel_rgb565   = {word.data_byte[7:3], green_ff[7:2], blue_ff[7:3]};
                  res.word.pixel_address  = ADDR_W'(addr_full);
                  res.word.image_width    = OUT_DIM_W'(img_w_ff);
                  res.word.image_height   = OUT_DIM_W'(img_h_ff);
                  res.word.last_pixel     = last_row && last_col;
                  if (!(last_row && last_col)) begin
                     col_in = DIM_W'(col_inc);
                     if (last_col) begin
                        if (row_pad != 2'd0) begin
                           pad_in = row_pad;
                        end else begin
                           col_in = '0;
                           row_in = DIM_W'(row_inc);
                        end
                     end
                  end
               end
            endcase
         end
         PH_PAD: begin
            pad_in = pad_cur - 2'd1;
            if (pad_cur == 2'd1) begin
               col_in = '0;
               row_in = DIM_W'(row_inc);
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      // file ended early: report replaces a non-final pixel
      if (word.end_of_file && (phase_main != PH_DONE)) begin
         res           = '0;
         res.valid     = 1'b1;
         res.word.kind = KIND_TRUNCATED;
         if (phase_main != PH_HEADER) begin
            if (phase_cur == PH_HEADER) begin
               res.word.image_width  = OUT_DIM_W'(width_ff);
               res.word.image_height = OUT_DIM_W'(habs);
            end else begin
               res.word.image_width  = OUT_DIM_W'(img_w_ff);
               res.word.image_height = OUT_DIM_W'(img_h_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         pos_ff      <= '0;
         magic_ff    <= '0;
         offset_ff   <= '0;
         width_ff    <= '0;
         height_ff   <= '0;
         depth_ff    <= '0;
         comp_ff     <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         bip_ff      <= BIP_BLUE;
         pad_ff      <= '0;
         blue_ff     <= '0;
         green_ff    <= '0;
         img_w_ff    <= '0;
         img_h_ff    <= '0;
         top_down_ff <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         magic_ff    <= magic_in;
         offset_ff   <= offset_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         depth_ff    <= depth_in;
         comp_ff     <= comp_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         bip_ff      <= bip_in;
         pad_ff      <= pad_in;
         blue_ff     <= blue_in;
         green_ff    <= green_in;
         img_w_ff    <= img_w_in;
         img_h_ff    <= img_h_in;
         top_down_ff <= top_down_in;
      end
   end

endmodule

// File: rtl/core/bmp565_rsp_reg.sv
// Result register on the output side of the decoder.
module bmp565_rsp_reg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  bmp565_pkg::rsp_word_type load_word,
   output logic                     space,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output bmp565_pkg::rsp_word_type rsp_word
);
   import bmp565_pkg::*;

   logic         valid_ff, valid_in;
   rsp_word_type word_ff;

   // a new word may load in the same cycle the held one leaves
   assign space     = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= load_word;
      end
   end

endmodule

// File: tb/sv/bmp24_to_rgb565_decoder_core_test.sv
// Self-checking testbench for the BMP (24-bit) to RGB565 decoder core.
module bmp24_to_rgb565_decoder_core_test;
   import bmp565_pkg::*;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int FEED_BYTES   = 550;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_CAP   = 50;

   typedef struct {
      logic [15:0]  magic;
      logic [15:0]  depth;
      logic [31:0]  offset;
      logic [31:0]  width;
      logic [31:0]  height;
      logic [31:0]  comp;
      int           total;         // file length; 0 means the whole image
      bit           keep_last_pad;
      bit           sof;
      bit           eof;
      int           fill;          // body byte value, -1 for random
      int           trail;         // bytes sent after the file ends
      int           typed_at;      // byte index carrying a fixed expectation, -1 for none
      rsp_word_type want;
   } file_spec_type;

   typedef struct packed {
      req_word_type word;
      logic         typed;
      rsp_word_type want;
   } feed_item_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_word;

   bmp24_to_rgb565_decoder_core DUT (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_word,
      .rsp_valid,
      .rsp_ready,
      .rsp_word
   );

   // decoder shadow state
   phase_type   parse_phase;
   logic [31:0] file_pos;
   logic [15:0] sig_word;
   logic [31:0] data_start;
   logic [31:0] img_w;
   logic [31:0] img_h;
   logic [15:0] bit_depth;
   logic [31:0] comp_code;
   logic [31:0] row_idx;
   logic [31:0] col_idx;
   logic [1:0]  color_slot;
   logic [1:0]  pad_count;
   logic [7:0]  blue_byte;
   logic [7:0]  green_byte;

   feed_item_type byte_feed[$];
   rsp_word_type  due_results[$];
   file_spec_type directed_files[$];
   feed_item_type offered;
   int            mismatches = 0;
   int            cycles = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void restart_parse();
      parse_phase = PH_HEADER;
      file_pos    = '0;
      sig_word    = '0;
      data_start  = '0;
      img_w       = '0;
      img_h       = '0;
      bit_depth   = '0;
      comp_code   = '0;
      row_idx     = '0;
      col_idx     = '0;
      color_slot  = BIP_BLUE;
      pad_count   = '0;
      blue_byte   = '0;
      green_byte  = '0;
   endfunction

   function automatic logic [31:0] rows_abs();
      return img_h[31] ? ~img_h + 32'd1 : img_h;
   endfunction

   function automatic bit header_accepted();
      if (sig_word != BMP_MAGIC || bit_depth != BMP_DEPTH || comp_code != '0) return 1'b0;
      if (img_w == '0 || img_w[31]) return 1'b0;
      if (img_h == '0) return 1'b0;
      if (img_w > MAX_WIDTH_U || rows_abs() > MAX_HEIGHT_U) return 1'b0;
      if (data_start < HEADER_BYTES) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void store_header_byte(logic [31:0] pos, logic [7:0] b);
      if (pos < POS_MAGIC + 32'd2)
         sig_word |= 16'(b) << (8 * (pos - POS_MAGIC));
      else if (pos >= POS_OFFSET && pos < POS_OFFSET + 32'd4)
         data_start |= 32'(b) << (8 * (pos - POS_OFFSET));
      else if (pos >= POS_WIDTH && pos < POS_WIDTH + 32'd4)
         img_w |= 32'(b) << (8 * (pos - POS_WIDTH));
      else if (pos >= POS_HEIGHT && pos < POS_HEIGHT + 32'd4)
         img_h |= 32'(b) << (8 * (pos - POS_HEIGHT));
      else if (pos >= POS_DEPTH && pos < POS_DEPTH + 32'd2)
         bit_depth |= 16'(b) << (8 * (pos - POS_DEPTH));
      else if (pos >= POS_COMP && pos < POS_COMP + 32'd4)
         comp_code |= 32'(b) << (8 * (pos - POS_COMP));
   endfunction

   // Advances the shadow decoder by one byte; returns 1 when the byte yields a result.
   function automatic bit decode_byte(input req_word_type w, output rsp_word_type r);
      logic [31:0] h;
      logic [31:0] dst_row;
      logic [31:0] addr;
      logic [31:0] pad;
      logic        last;
      bit          got;
      got = 1'b0;
      r = '0;
      if (w.start_of_file) restart_parse();
      case (parse_phase)
         PH_HEADER: begin
            store_header_byte(file_pos, w.data_byte);
            file_pos++;
            if (file_pos >= HEADER_BYTES) begin
               if (!header_accepted()) begin
                  r.kind = KIND_BAD_FORMAT;
                  parse_phase = PH_DONE;
                  return 1'b1;
               end
               parse_phase = (file_pos >= data_start) ? PH_PIXELS : PH_SKIP;
            end
         end
         PH_SKIP: begin
            file_pos++;
            if (file_pos >= data_start) parse_phase = PH_PIXELS;
         end
         PH_PIXELS: begin
            if (color_slot == BIP_BLUE) begin
               blue_byte = w.data_byte;
               color_slot = BIP_GREEN;
            end else if (color_slot == BIP_GREEN) begin
               green_byte = w.data_byte;
               color_slot = BIP_RED;
            end else begin
               h = rows_abs();
               dst_row = img_h[31] ? row_idx : h - 32'd1 - row_idx;
               addr = dst_row * img_w + col_idx;
               last = (row_idx + 32'd1 >= h) && (col_idx + 32'd1 >= img_w);
               color_slot = BIP_BLUE;
               r.kind = KIND_PIXEL;
               r.pixel_rgb565 = {w.data_byte[7:3], green_byte[7:2], blue_byte[7:3]};
               r.pixel_address = addr[ADDR_W-1:0];
               r.image_width = img_w[OUT_DIM_W-1:0];
               r.image_height = h[OUT_DIM_W-1:0];
               r.last_pixel = last;
               got = 1'b1;
               if (last) begin
                  parse_phase = PH_DONE;
                  return 1'b1;
               end
               col_idx++;
               if (col_idx >= img_w) begin
                  pad = (32'd4 - ((img_w * 32'd3) & 32'd3)) & 32'd3;
                  if (pad != '0) begin
                     pad_count = pad[1:0];
                     parse_phase = PH_PAD;
                  end else begin
                     col_idx = '0;
                     row_idx++;
                  end
               end
            end
         end
         PH_PAD: begin
            pad_count = pad_count - 2'd1;
            if (pad_count == '0) begin
               col_idx = '0;
               row_idx++;
               parse_phase = PH_PIXELS;
            end
         end
         default: begin
         end
      endcase
      // an early end replaces any non-final pixel finished on this byte
      if (w.end_of_file && parse_phase != PH_DONE) begin
         r = '0;
         r.kind = KIND_TRUNCATED;
         if (parse_phase != PH_HEADER) begin
            h = rows_abs();
            r.image_width = img_w[OUT_DIM_W-1:0];
            r.image_height = h[OUT_DIM_W-1:0];
         end
         parse_phase = PH_DONE;
         return 1'b1;
      end
      return got;
   endfunction

   function automatic rsp_word_type report(kind_type k, logic [15:0] rgb, logic [21:0] addr,
                                           logic [11:0] w, logic [11:0] h, logic last);
      rsp_word_type r;
      r.kind = k;
      r.pixel_rgb565 = rgb;
      r.pixel_address = addr;
      r.image_width = w;
      r.image_height = h;
      r.last_pixel = last;
      return r;
   endfunction

   function automatic file_spec_type image_file(logic [31:0] w, logic [31:0] h,
                                                logic [31:0] off);
      file_spec_type f;
      f.magic = BMP_MAGIC;
      f.depth = BMP_DEPTH;
      f.offset = off;
      f.width = w;
      f.height = h;
      f.comp = '0;
      f.total = 0;
      f.keep_last_pad = 1'b0;
      f.sof = 1'b1;
      f.eof = 1'b1;
      f.fill = -1;
      f.trail = 0;
      f.typed_at = -1;
      f.want = '0;
      return f;
   endfunction

   function automatic file_spec_type rejected(file_spec_type f);
      f.total = 60;
      f.typed_at = 53;
      f.want = report(KIND_BAD_FORMAT, '0, '0, '0, '0, 1'b0);
      return f;
   endfunction

   function automatic file_spec_type cut_short(file_spec_type f, int n,
                                               logic [11:0] w, logic [11:0] h);
      f.total = n;
      f.typed_at = n - 1;
      f.want = report(KIND_TRUNCATED, '0, '0, w, h, 1'b0);
      return f;
   endfunction

   function automatic int file_length(file_spec_type f);
      int start;
      int row;
      int pad;
      int habs;
      habs = f.height[31] ? int'(-f.height) : int'(f.height);
      row = int'(f.width) * 3;
      pad = (4 - row % 4) % 4;
      start = (f.offset < HEADER_BYTES) ? 54 : int'(f.offset);
      return start + habs * (row + pad) - (f.keep_last_pad ? 0 : pad);
   endfunction

   task automatic add_file(input file_spec_type f);
      logic [7:0]    hdr [54];
      feed_item_type it;
      int            n;
      n = (f.total > 0) ? f.total : file_length(f);
      for (int p = 0; p < 54; p++) hdr[p] = 8'($urandom);
      hdr[0] = f.magic[7:0];
      hdr[1] = f.magic[15:8];
      for (int p = 0; p < 4; p++) begin
         hdr[10 + p] = f.offset[8*p +: 8];
         hdr[18 + p] = f.width[8*p +: 8];
         hdr[22 + p] = f.height[8*p +: 8];
         hdr[30 + p] = f.comp[8*p +: 8];
      end
      hdr[28] = f.depth[7:0];
      hdr[29] = f.depth[15:8];
      for (int p = 0; p < n + f.trail; p++) begin
         it = '0;
         if (p < 54) it.word.data_byte = hdr[p];
         else if (f.fill >= 0) it.word.data_byte = 8'(f.fill);
         else it.word.data_byte = 8'($urandom);
         it.word.start_of_file = f.sof && p == 0;
         if (p == n - 1) it.word.end_of_file = f.eof;
         else if (p >= n) it.word.end_of_file = ($urandom_range(0, 3) == 0);
         if (p == f.typed_at) begin
            it.typed = 1'b1;
            it.want = f.want;
         end
         byte_feed.push_back(it);
      end
   endtask

   task automatic add_random_file();
      file_spec_type f;
      feed_item_type it;
      int            sel;
      int            habs;
      sel = $urandom_range(0, 9);
      if (sel == 8) begin
         // loose bytes with random start and end flags
         repeat ($urandom_range(1, 16)) begin
            it = '0;
            it.word.data_byte = 8'($urandom);
            it.word.start_of_file = ($urandom_range(0, 5) == 0);
            it.word.end_of_file = ($urandom_range(0, 5) == 0);
            byte_feed.push_back(it);
         end
         return;
      end
      habs = $urandom_range(1, 4);
      f = image_file($urandom_range(1, 5), $urandom_range(0, 1) ? 32'(-habs) : 32'(habs),
                     ($urandom_range(0, 3) == 0) ? 54 + $urandom_range(1, 12) : 54);
      f.keep_last_pad = $urandom_range(0, 1);
      f.eof = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) f.trail = $urandom_range(1, 4);
      if (sel == 6 || sel == 9) begin
         f.total = $urandom_range(1, file_length(f));
         f.eof = (sel == 6);
      end else if (sel == 7) begin
         case ($urandom_range(0, 6))
            0: f.magic[$urandom_range(0, 15)] ^= 1'b1;
            1: f.depth = 16'($urandom_range(0, 64));
            2: f.comp = 32'($urandom_range(1, 3));
            3: f.width = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(2049, 70000));
            4: f.height = $urandom_range(0, 1) ? 32'd0 : 32'(-$urandom_range(2049, 5000));
            5: f.offset = 32'($urandom_range(0, 53));
            default: f.width = 32'h8000_0000 | 32'($urandom);
         endcase
         f.total = 54 + $urandom_range(0, 6);
      end
      add_file(f);
   endtask

   function automatic int draw_wait(inout int run_left, inout bit steady);
      if (run_left == 0) begin
         steady = ($urandom_range(0, 2) == 0);
         run_left = $urandom_range(16, 160);
      end
      run_left--;
      return steady ? 0 : $urandom_range(0, 14);
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_CAP)
            $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : result_check
      rsp_word_type want;
      rsp_word_type predicted;
      bit           hit;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_CAP)
                  $display("%0t: expected no word, got %h", $time, rsp_word);
            end else begin
               want = due_results.pop_front();
               compare_field("kind", want.kind, rsp_word.kind);
               compare_field("pixel_rgb565", want.pixel_rgb565, rsp_word.pixel_rgb565);
               compare_field("pixel_address", want.pixel_address, rsp_word.pixel_address);
               compare_field("image_width", want.image_width, rsp_word.image_width);
               compare_field("image_height", want.image_height, rsp_word.image_height);
               compare_field("last_pixel", want.last_pixel, rsp_word.last_pixel);
            end
         end
         if (req_valid && req_ready) begin
            hit = decode_byte(req_word, predicted);
            if (offered.typed) due_results.push_back(offered.want);
            else if (hit) due_results.push_back(predicted);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver: random stalls, plus two long hold-offs that back the block up
   initial begin : receiver
      int  stall;
      int  taken;
      int  run_left;
      bit  steady;
      taken = 0;
      run_left = 0;
      steady = 1'b0;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = draw_wait(run_left, steady);
         if (taken == 3 || taken == 10) stall = LONG_HOLD;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
         @(negedge clock);
      end
   end

   initial begin : sender
      file_spec_type f;
      int            gap;
      int            run_left;
      bit            steady;
      run_left = 0;
      steady = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      offered = '0;
      restart_parse();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // parser starts at byte 0 even without a start flag
      f = image_file(1, 1, 54); f.sof = 1'b0; f.fill = 8'hFF; f.typed_at = 56;
      f.want = report(KIND_PIXEL, 16'hFFFF, '0, 12'd1, 12'd1, 1'b1);
      directed_files.push_back(f);
      // top-down rows, skipped gap, trailing bytes that must be ignored
      f = image_file(3, 32'hFFFF_FFFE, 60); f.keep_last_pad = 1'b1; f.trail = 5;
      directed_files.push_back(f);
      directed_files.push_back(rejected(image_file(2049, 2, 54)));
      // bad format and file end on the same byte
      f = image_file(2, 2, 54); f.depth = 16'd8; f = rejected(f); f.total = 54;
      directed_files.push_back(f);
      directed_files.push_back(cut_short(image_file(3, 2, 54), 20, 12'd0, 12'd0));
      directed_files.push_back(cut_short(image_file(2, 2, 54), 57, 12'd2, 12'd2));
      // largest accepted sizes, cut short so that only the first pixel comes out
      f = image_file(2048, 32'hFFFF_FFFF, 54);
      directed_files.push_back(cut_short(f, 60, 12'd2048, 12'd1));
      f = image_file(1, 2048, 54);
      directed_files.push_back(cut_short(f, 60, 12'd1, 12'd2048));

      foreach (directed_files[i]) add_file(directed_files[i]);
      while (byte_feed.size() < FEED_BYTES) add_random_file();

      foreach (byte_feed[i]) begin
         gap = draw_wait(run_left, steady);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         offered = byte_feed[i];
         req_word <= byte_feed[i].word;
         req_valid <= 1'b1;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         @(negedge clock);
      end
      req_valid <= 1'b0;

      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
